// ===== sv/rf4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf4_pkg
// shared types, constants and elaboration-time twiddle generation for the
// radix-4 frame transform
// ----------------------------------------------------------------------------
package rf4_pkg;

    localparam int RES_W     = 26;
    localparam int BIN_IDX_W = 10;
    localparam int LOG_W     = 3;
    localparam logic [LOG_W-1:0] LOG_RST = 3'd5;
    localparam int TW_PACK_W = 24;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FFT  = 4'b0010,
        S_RD   = 4'b0100,
        S_SPARE = 4'b1000
    } t_state;

    // largest exponent with 4^l <= mp
    function automatic int calc_lmax(input int mp);
        int l;
        l = 1;
        while ((4 << (2 * l)) <= mp) l++;
        return l;
    endfunction

    function automatic longint unsigned tw_round(input longint unsigned v, input int twb);
        longint unsigned q;
        longint unsigned top;
        q   = (v + (64'd1 << (29 - (twb - 1)))) >> (30 - (twb - 1));
        top = (64'd1 << (twb - 1)) - 1;
        return (q > top) ? top : q;
    endfunction

    // W = exp(-j*2*pi*num/2^lg_den), packed {re, im}, each TW_PACK_W bits
    function automatic logic [2*TW_PACK_W-1:0] tw_calc(input int num, input int lg_den,
                                                       input int twb);
        longint unsigned one_q30;
        longint unsigned n4, qd, r, den, rr, t, t2, c, s, cr, sr;
        longint signed ca, sa, wr, wi;
        logic swp;
        one_q30 = 64'd1073741824;
        n4  = 4 * longint'(num);
        qd  = n4 >> lg_den;
        r   = n4 - (qd << lg_den);
        den = 64'd1 << lg_den;
        swp = (2 * r > den);
        rr  = swp ? den - r : r;
        t   = (64'd1686629713 * rr) >> lg_den;
        t2  = (t * t) >> 30;
        c   = one_q30;
        s   = one_q30;
        c = one_q30 - ((t2 * c) >> 30) / 132; s = one_q30 - ((t2 * s) >> 30) / 156;
        c = one_q30 - ((t2 * c) >> 30) / 90;  s = one_q30 - ((t2 * s) >> 30) / 110;
        c = one_q30 - ((t2 * c) >> 30) / 56;  s = one_q30 - ((t2 * s) >> 30) / 72;
        c = one_q30 - ((t2 * c) >> 30) / 30;  s = one_q30 - ((t2 * s) >> 30) / 42;
        c = one_q30 - ((t2 * c) >> 30) / 12;  s = one_q30 - ((t2 * s) >> 30) / 20;
        c = one_q30 - ((t2 * c) >> 30) / 2;   s = one_q30 - ((t2 * s) >> 30) / 6;
        cr = tw_round(c, twb);
        sr = tw_round((t * s) >> 30, twb);
        if (swp) begin
            c = sr; s = cr;
        end else begin
            c = cr; s = sr;
        end
        case (qd & 3)
            0: begin ca = c;  sa = s;  end
            1: begin ca = -longint'(s); sa = c; end
            2: begin ca = -longint'(c); sa = -longint'(s); end
            default: begin ca = s; sa = -longint'(c); end
        endcase
        wr = ca;
        wi = -sa;
        return {wr[TW_PACK_W-1:0], wi[TW_PACK_W-1:0]};
    endfunction

endpackage

// ===== sv/radix4_fft_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix4_fft_frame
// in-place radix-4 decimation-in-time fft over a frame of 4^L complex samples
// ----------------------------------------------------------------------------
// user notes: a write transfer (cmd 0) stores one sample at its digit-reversed
// address. the transfer that completes a frame starts the transform: L stages
// of N/4 butterflies, each butterfly run on the one shared complex multiplier
// (four reads through the single memory read port, multiply, round, then four
// writes through the single write port); the block accepts nothing until the
// transform is through. a read transfer (cmd 1), held by any wait on the
// result side, returns the next bin in natural order, or all zeros when no
// transformed frame is held. results are unscaled, 26-bit, saturating at each
// butterfly; twiddles are built at elaboration as a quarter-wave table and
// rotated by quadrant on the way out.
// ----------------------------------------------------------------------------
module radix4_fft_frame #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rf4_pkg::LOG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_im,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rf4_pkg::RES_W-1:0]    o_bin_re,
    output logic signed [rf4_pkg::RES_W-1:0]    o_bin_im,
    output logic [rf4_pkg::BIN_IDX_W-1:0]       o_bin_index,
    output logic                                o_last_bin,
    output logic                                o_frame_ready
);
    import rf4_pkg::*;

    localparam int LMAX = calc_lmax(MAX_POINTS);
    localparam int AW   = 2 * LMAX;
    localparam int NPTS = 1 << AW;
    localparam int QW   = (AW > 2) ? AW - 2 : 1;   // quarter-wave table index
    localparam int QN   = 1 << QW;
    localparam int SW   = $clog2(LMAX + 1);
    localparam int TWB  = TWIDDLE_BITS;
    localparam int PRW  = RES_W + TWB;       // one real product
    localparam int CW   = RES_W + 2;         // rounded product
    localparam int BW   = CW + 2;            // butterfly sum

    // sample store, {re, im}
    logic [2*RES_W-1:0] mem [NPTS];
    // first quadrant of the twiddle circle
    logic [2*TW_PACK_W-1:0] tw_rom [QN];

    for (genvar g = 0; g < QN; g++) begin : g_tw
        localparam logic [2*TW_PACK_W-1:0] W = tw_calc(g, AW, TWB);
        assign tw_rom[g] = W;
    end

    t_state r_state;
    logic [LOG_W-1:0] r_log4;
    logic [AW:0]      r_wr_cnt;
    logic [AW:0]      r_rd_cnt;
    logic             r_have;
    logic [SW-1:0]    r_stage;
    logic [AW-1:0]    r_bfly;
    logic [3:0]       r_cyc;

    // effective exponent and frame length
    logic [SW-1:0] eff_l;
    logic [AW:0]   frame_len;
    always_comb begin
        if (r_log4 < LOG_W'(1))
            eff_l = SW'(1);
        else if (r_log4 > LOG_W'(LMAX))
            eff_l = SW'(LMAX);
        else
            eff_l = SW'(r_log4);
        frame_len = (AW+1)'(1) << (2 * eff_l);
    end

    function automatic logic [AW-1:0] dig_rev(input logic [AW-1:0] x, input logic [SW-1:0] l);
        logic [AW-1:0] rev;
        for (int d = 0; d < LMAX; d++) rev[2*d +: 2] = x[2*(LMAX-1-d) +: 2];
        return rev >> (2 * (LMAX - l));
    endfunction

    logic in_xfer, wr_xfer, rd_xfer;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign wr_xfer    = in_xfer && !i_cmd;
    assign rd_xfer    = in_xfer && i_cmd;

    // butterfly addressing
    logic [AW-1:0] q_msk, k_idx, i0;
    logic [4:0]    sh;
    logic [1:0]    rd_j, wr_j;
    logic          last_bfly, last_stage;
    always_comb begin
        sh    = 5'(2 * (r_stage - SW'(1)));
        q_msk = (AW'(1) << sh) - AW'(1);
        k_idx = r_bfly & q_msk;
        i0    = ((r_bfly >> sh) << (sh + 5'd2)) | k_idx;
        rd_j  = r_cyc[1:0];
        wr_j  = 2'(r_cyc - 4'd6);
        last_bfly  = ((AW+1)'(r_bfly) == (frame_len >> 2) - (AW+1)'(1));
        last_stage = (r_stage == eff_l);
    end

    // write count wraps once a frame has been completed
    logic [AW:0] wc_use;
    assign wc_use = (r_wr_cnt >= frame_len) ? '0 : r_wr_cnt;

    // memory ports
    logic [AW-1:0]      rd_addr, wr_addr, tw_addr;
    logic               we;
    logic [2*RES_W-1:0] wdata;
    logic [2*RES_W-1:0] r_q;
    logic [2*TW_PACK_W-1:0] r_tw;
    logic [1:0]         r_tw_qd;
    logic [AW+1:0] jk;

    always_comb begin
        jk      = (AW+2)'(rd_j) * (AW+2)'(k_idx);
        tw_addr = AW'(jk << (2 * (LMAX - r_stage)));
        if (r_state == S_FFT)
            rd_addr = i0 + (AW'(rd_j) << sh);
        else
            rd_addr = r_rd_cnt[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_q     <= mem[rd_addr];
        r_tw    <= tw_rom[tw_addr[QW-1:0]];
        r_tw_qd <= tw_addr[AW-1 -: 2];
        if (we) mem[wr_addr] <= wdata;
    end

    // twiddle rotated into its quadrant, a multiple of -j each
    logic signed [TWB-1:0] w0_re, w0_im;
    logic signed [TWB-1:0] w_re, w_im;
    assign w0_re = r_tw[TW_PACK_W +: TWB];
    assign w0_im = r_tw[0 +: TWB];
    always_comb begin
        case (r_tw_qd)
            2'd0: begin w_re = w0_re;  w_im = w0_im;  end
            2'd1: begin w_re = w0_im;  w_im = -w0_re; end
            2'd2: begin w_re = -w0_re; w_im = -w0_im; end
            default: begin w_re = -w0_im; w_im = w0_re; end
        endcase
    end

    // shared complex multiplier, one element per cycle
    logic signed [RES_W-1:0] a_re, a_im;
    logic signed [PRW-1:0]   r_ac, r_bd, r_ad, r_bc;
    logic signed [RES_W-1:0] r_d_re, r_d_im;
    assign a_re = r_q[2*RES_W-1:RES_W];
    assign a_im = r_q[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        r_ac   <= PRW'(a_re * w_re);
        r_bd   <= PRW'(a_im * w_im);
        r_ad   <= PRW'(a_re * w_im);
        r_bc   <= PRW'(a_im * w_re);
        r_d_re <= a_re;
        r_d_im <= a_im;
    end

    // round half up and collect the four butterfly inputs
    logic signed [PRW:0]  sum_re, sum_im;
    logic signed [CW-1:0] r_sl_re [4];
    logic signed [CW-1:0] r_sl_im [4];
    logic [1:0] sl_j;
    assign sl_j   = 2'(r_cyc - 4'd2);
    assign sum_re = (PRW+1)'(r_ac) - (PRW+1)'(r_bd) + ((PRW+1)'(1) << (TWB - 2));
    assign sum_im = (PRW+1)'(r_ad) + (PRW+1)'(r_bc) + ((PRW+1)'(1) << (TWB - 2));

    always_ff @(posedge i_clk) begin
        if (r_state == S_FFT && r_cyc >= 4'd2 && r_cyc <= 4'd5) begin
            if (sl_j == 2'd0) begin
                r_sl_re[sl_j] <= CW'(r_d_re);
                r_sl_im[sl_j] <= CW'(r_d_im);
            end else begin
                r_sl_re[sl_j] <= CW'(sum_re >>> (TWB - 1));
                r_sl_im[sl_j] <= CW'(sum_im >>> (TWB - 1));
            end
        end
    end

    // 4-point dft, one output per cycle
    logic signed [BW-1:0] m_re, m_im, a1r, a1i, b2r, b2i, c3r, c3i, y_re, y_im;
    function automatic logic signed [RES_W-1:0] sat(input logic signed [BW-1:0] x);
        if (x > BW'(2**(RES_W-1) - 1)) return {1'b0, {(RES_W-1){1'b1}}};
        if (x < -BW'(2**(RES_W-1)))    return {1'b1, {(RES_W-1){1'b0}}};
        return RES_W'(x);
    endfunction

    always_comb begin
        m_re = BW'(r_sl_re[0]); m_im = BW'(r_sl_im[0]);
        a1r  = BW'(r_sl_re[1]); a1i  = BW'(r_sl_im[1]);
        b2r  = BW'(r_sl_re[2]); b2i  = BW'(r_sl_im[2]);
        c3r  = BW'(r_sl_re[3]); c3i  = BW'(r_sl_im[3]);
        case (wr_j)
            2'd0: begin y_re = m_re + a1r + b2r + c3r; y_im = m_im + a1i + b2i + c3i; end
            2'd1: begin y_re = m_re + a1i - b2r - c3i; y_im = m_im - a1r - b2i + c3r; end
            2'd2: begin y_re = m_re - a1r + b2r - c3r; y_im = m_im - a1i + b2i - c3i; end
            default: begin y_re = m_re - a1i - b2r + c3i; y_im = m_im + a1r - b2i - c3r; end
        endcase
    end

    // write port: incoming samples or butterfly results
    always_comb begin
        if (r_state == S_FFT) begin
            we      = (r_cyc >= 4'd6);
            wr_addr = i0 + (AW'(wr_j) << sh);
            wdata   = {sat(y_re), sat(y_im)};
        end else begin
            we      = wr_xfer;
            wr_addr = dig_rev(wc_use[AW-1:0], eff_l);
            wdata   = {RES_W'(i_sample_re), RES_W'(i_sample_im)};
        end
    end

    // sequencer
    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_log4      <= LOG_RST;
            r_wr_cnt    <= '0;
            r_rd_cnt    <= '0;
            r_have      <= 1'b0;
            r_stage     <= SW'(1);
            r_bfly      <= '0;
            r_cyc       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // result valid: set when a bin is loaded, cleared when taken
            if (r_state == S_RD && out_free)
                o_out_valid <= 1'b1;
            else if (i_out_ready)
                o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_log4   <= i_cfg_data;
                        r_wr_cnt <= '0;
                        r_rd_cnt <= '0;
                        r_have   <= 1'b0;
                    end else if (wr_xfer) begin
                        r_have   <= 1'b0;
                        r_rd_cnt <= '0;
                        r_wr_cnt <= wc_use + (AW+1)'(1);
                        if (wc_use + (AW+1)'(1) == frame_len) begin
                            r_state <= S_FFT;
                            r_stage <= SW'(1);
                            r_bfly  <= '0;
                            r_cyc   <= '0;
                        end
                    end else if (rd_xfer) begin
                        r_state <= S_RD;
                    end
                end
                S_FFT: begin
                    if (r_cyc == 4'd9) begin
                        r_cyc <= '0;
                        if (last_bfly) begin
                            r_bfly <= '0;
                            if (last_stage) begin
                                r_state  <= S_IDLE;
                                r_have   <= 1'b1;
                                r_wr_cnt <= '0;
                                r_rd_cnt <= '0;
                            end else begin
                                r_stage <= r_stage + SW'(1);
                            end
                        end else begin
                            r_bfly <= r_bfly + AW'(1);
                        end
                    end else begin
                        r_cyc <= r_cyc + 4'd1;
                    end
                end
                S_RD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_have && r_rd_cnt < frame_len) begin
                            if (r_rd_cnt + (AW+1)'(1) >= frame_len) begin
                                r_rd_cnt <= '0;
                                r_have   <= 1'b0;
                            end else begin
                                r_rd_cnt <= r_rd_cnt + (AW+1)'(1);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    logic hit;
    assign hit = r_have && (r_rd_cnt < frame_len);
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD && out_free) begin
            o_bin_re      <= hit ? r_q[2*RES_W-1:RES_W] : '0;
            o_bin_im      <= hit ? r_q[RES_W-1:0] : '0;
            o_bin_index   <= hit ? BIN_IDX_W'(r_rd_cnt) : '0;
            o_last_bin    <= hit && (r_rd_cnt == frame_len - (AW+1)'(1));
            o_frame_ready <= hit;
        end
    end

endmodule

// ===== bench/radix4_fft_frame_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix4_fft_frame_tb
// self-checking bench: random and directed sample/bin transfers with random
// idling on both channels, a bit-exact fixed-point transform predictor and an
// in-order comparison of every returned bin
// ----------------------------------------------------------------------------
module radix4_fft_frame_tb;

    import rf4_pkg::*;

    localparam int SAMPLE_W  = 16;
    localparam int PTS_MAX   = 1024;
    localparam int FRAC_W    = 17;               // twiddle fraction bits
    localparam int WD_LIMIT  = 100000;           // idle cycles before timeout
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_req;

    typedef struct {
        logic signed [RES_W-1:0]     re;
        logic signed [RES_W-1:0]     im;
        logic [BIN_IDX_W-1:0]        idx;
        logic                        last;
        logic                        rdy;
    } t_bin;

    // dut connections
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [LOG_W-1:0]           i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_cmd = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_re = '0;
    logic signed [SAMPLE_W-1:0] i_sample_im = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [RES_W-1:0]    o_bin_re;
    logic signed [RES_W-1:0]    o_bin_im;
    logic [BIN_IDX_W-1:0]       o_bin_index;
    logic                       o_last_bin;
    logic                       o_frame_ready;

    radix4_fft_frame dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bin_re      (o_bin_re),
        .o_bin_im      (o_bin_im),
        .o_bin_index   (o_bin_index),
        .o_last_bin    (o_last_bin),
        .o_frame_ready (o_frame_ready)
    );

    always #5 i_clk = ~i_clk;

    // pending transfers and the bins they are predicted to return
    t_req   pending_reqs[$];
    t_bin   expected_bins[$];
    int     fail_count = 0;
    int     req_total = 0;

    // ------------------------------------------------------------------------
    // predictor state: a private copy of the frame store and the counters
    // ------------------------------------------------------------------------
    longint     frame_re[PTS_MAX];
    longint     frame_im[PTS_MAX];
    int         wr_count = 0;
    int         rd_count = 0;
    bit         frame_held = 1'b0;
    logic [2:0] size_reg = LOG_RST;

    // exponent in use, clamped to 1..5 for a 1024-point store
    function automatic int used_log4();
        int l;
        l = int'(size_reg);
        if (l < 1) l = 1;
        if (l > 5) l = 5;
        return l;
    endfunction

    function automatic longint unsigned tw_quantise(input longint unsigned v);
        longint unsigned q;
        q = (v + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
        return (q > (64'd1 << FRAC_W) - 1) ? (64'd1 << FRAC_W) - 1 : q;
    endfunction

    // cos and sin magnitudes of (pi/2)*r/den by a q30 taylor series
    task automatic trig_q30(input longint unsigned r, input longint unsigned den,
                            output longint unsigned co, output longint unsigned si);
        longint unsigned t, t2, c, s;
        t  = HALF_PI_Q30 * r / den;
        t2 = (t * t) >> 30;
        c  = ONE_Q30;
        s  = ONE_Q30;
        for (int i = 6; i >= 1; i--) begin
            c = ONE_Q30 - ((t2 * c) >> 30) / ((2 * i - 1) * (2 * i));
            s = ONE_Q30 - ((t2 * s) >> 30) / ((2 * i) * (2 * i + 1));
        end
        co = tw_quantise(c);
        si = tw_quantise((t * s) >> 30);
    endtask

    // exp(-j*2*pi*num/den), folded by quadrant and complement
    task automatic twiddle_of(input longint unsigned num, input longint unsigned den,
                              output longint wr, output longint wi);
        longint unsigned quad, r, c, s;
        longint ca, sa;
        quad = (4 * num) / den;
        r    = 4 * num - quad * den;
        if (2 * r > den) trig_q30(den - r, den, s, c);
        else trig_q30(r, den, c, s);
        case (quad & 3)
            0: begin ca = c;   sa = s;  end
            1: begin ca = -s;  sa = c;  end
            2: begin ca = -c;  sa = -s; end
            default: begin ca = s; sa = -c; end
        endcase
        wr = ca;
        wi = -sa;
    endtask

    task automatic twiddle_mul(input longint a, input longint b, input longint c,
                               input longint d, output longint re, output longint im);
        longint half;
        half = longint'(1) << (FRAC_W - 1);
        re = (a * c - b * d + half) >>> FRAC_W;
        im = (a * d + b * c + half) >>> FRAC_W;
    endtask

    function automatic longint clip26(input longint x);
        longint lim;
        lim = longint'(1) << (RES_W - 1);
        if (x > lim - 1) return lim - 1;
        if (x < -lim) return -lim;
        return x;
    endfunction

    task automatic transform_frame(input int n);
        int q, i0, i1, i2, i3;
        longint w1r, w1i, w2r, w2i, w3r, w3i, mr, mi, ar, ai, br, bi, cr, ci;
        for (int s = 4; s <= n; s *= 4) begin
            q = s / 4;
            for (int base = 0; base < n; base += s) begin
                for (int k = 0; k < q; k++) begin
                    i0 = base + k; i1 = i0 + q; i2 = i1 + q; i3 = i2 + q;
                    twiddle_of(longint'(k), longint'(s), w1r, w1i);
                    twiddle_of(longint'(2 * k), longint'(s), w2r, w2i);
                    twiddle_of(longint'(3 * k), longint'(s), w3r, w3i);
                    mr = frame_re[i0];
                    mi = frame_im[i0];
                    twiddle_mul(frame_re[i1], frame_im[i1], w1r, w1i, ar, ai);
                    twiddle_mul(frame_re[i2], frame_im[i2], w2r, w2i, br, bi);
                    twiddle_mul(frame_re[i3], frame_im[i3], w3r, w3i, cr, ci);
                    frame_re[i0] = clip26(mr + ar + br + cr);
                    frame_im[i0] = clip26(mi + ai + bi + ci);
                    frame_re[i1] = clip26(mr + ai - br - ci);
                    frame_im[i1] = clip26(mi - ar - bi + cr);
                    frame_re[i2] = clip26(mr - ar + br - cr);
                    frame_im[i2] = clip26(mi - ai + bi - ci);
                    frame_re[i3] = clip26(mr - ai - br + ci);
                    frame_im[i3] = clip26(mi + ar - bi - cr);
                end
            end
        end
    endtask

    // applies one accepted transfer to the predictor
    task automatic predict_transfer(input t_req r);
        int l, n, pos, x;
        t_bin b;
        l = used_log4();
        n = 1 << (2 * l);
        if (r.cmd == CMD_WRITE) begin
            if (frame_held) begin
                frame_held = 1'b0;
                rd_count = 0;
            end
            if (wr_count >= n) wr_count = 0;
            pos = 0;
            x = wr_count;
            for (int d = 0; d < l; d++) begin
                pos = (pos << 2) | (x & 3);
                x = x >> 2;
            end
            frame_re[pos] = longint'(r.re);
            frame_im[pos] = longint'(r.im);
            wr_count++;
            if (wr_count == n) begin
                transform_frame(n);
                frame_held = 1'b1;
                wr_count = 0;
                rd_count = 0;
            end
        end else begin
            if (!frame_held || rd_count >= n) begin
                b = '{re: '0, im: '0, idx: '0, last: 1'b0, rdy: 1'b0};
            end else begin
                b.re   = frame_re[rd_count][RES_W-1:0];
                b.im   = frame_im[rd_count][RES_W-1:0];
                b.idx  = rd_count[BIN_IDX_W-1:0];
                b.last = (rd_count == n - 1);
                b.rdy  = 1'b1;
                rd_count++;
                if (rd_count >= n) begin
                    rd_count = 0;
                    frame_held = 1'b0;
                end
            end
            expected_bins.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued transfers with random gaps, holds until accepted
    // ------------------------------------------------------------------------
    int  in_gap = 0;
    bit  in_burst = 1'b0;          // no idling on the input while set
    bit  in_accept;
    bit  out_accept;
    t_req cur_req;

    function automatic int pick_gap();
        if ($urandom_range(0, 11) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur_req.cmd = i_cmd;
                cur_req.re  = i_sample_re;
                cur_req.im  = i_sample_im;
                predict_transfer(cur_req);
            end
            // the slot is free when nothing is offered or the offer just went
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_cmd       <= cur_req.cmd;
                    i_sample_re <= cur_req.re;
                    i_sample_im <= cur_req.im;
                    i_in_valid  <= 1'b1;
                    in_gap <= in_burst ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, long hold-off on request, bin checking
    // ------------------------------------------------------------------------
    int  out_gap = 0;
    int  hold_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    t_bin exp_bin;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bins.size() == 0) begin
                    $display("%0t: unexpected bin transfer re %0d im %0d idx %0d",
                             $time, o_bin_re, o_bin_im, o_bin_index);
                    fail_count++;
                end else begin
                    exp_bin = expected_bins.pop_front();
                    if (o_bin_re !== exp_bin.re) begin
                        $display("%0t: bin_re expected %0d actual %0d",
                                 $time, exp_bin.re, o_bin_re);
                        fail_count++;
                    end
                    if (o_bin_im !== exp_bin.im) begin
                        $display("%0t: bin_im expected %0d actual %0d",
                                 $time, exp_bin.im, o_bin_im);
                        fail_count++;
                    end
                    if (o_bin_index !== exp_bin.idx) begin
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $time, exp_bin.idx, o_bin_index);
                        fail_count++;
                    end
                    if (o_last_bin !== exp_bin.last) begin
                        $display("%0t: last_bin expected %0b actual %0b",
                                 $time, exp_bin.last, o_last_bin);
                        fail_count++;
                    end
                    if (o_frame_ready !== exp_bin.rdy) begin
                        $display("%0t: frame_ready expected %0b actual %0b",
                                 $time, exp_bin.rdy, o_frame_ready);
                        fail_count++;
                    end
                end
            end
            // next ready level
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= 400;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (in_burst) begin
                i_out_ready <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) out_gap <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no transfer and no register write
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        in_accept  = i_in_valid && o_in_ready;
        out_accept = o_out_valid && i_out_ready;
        if (in_accept || out_accept || i_cfg_we || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic queue_req(input logic cmd, input logic signed [SAMPLE_W-1:0] re,
                             input logic signed [SAMPLE_W-1:0] im);
        t_req r;
        r.cmd = cmd;
        r.re  = re;
        r.im  = im;
        pending_reqs.push_back(r);
        req_total++;
    endtask

    // sender pauses until everything queued is accepted and every bin is back
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_bins.size() > 0)
            @(posedge i_clk);
    endtask

    // lets a transform started by the last write run out before reconfiguring
    task automatic settle_and_write_size(input logic [2:0] v);
        int l;
        wait_drained();
        l = used_log4();
        repeat (10 * l * (1 << (2 * l)) / 4 + 100) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        size_reg   = v;
        wr_count   = 0;
        rd_count   = 0;
        frame_held = 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // well-formed frames with random content, with some noise and broken frames
    task automatic queue_frames(input int frames);
        int n, reads;
        n = 1 << (2 * used_log4());
        for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < n; i++) begin
                queue_req(CMD_WRITE, rand_sample(), rand_sample());
                if ($urandom_range(0, 39) == 0)
                    queue_req(CMD_READ, rand_sample(), rand_sample());
            end
            case ($urandom_range(0, 7))
                0: reads = $urandom_range(0, n - 1);     // frame dropped by next write
                1: reads = n + $urandom_range(1, 3);     // reads past the frame
                default: reads = n;
            endcase
            for (int i = 0; i < reads; i++) queue_req(CMD_READ, rand_sample(), rand_sample());
        end
    endtask

    logic [2:0] rand_cfg;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reads with no frame at the reset size
        queue_req(CMD_READ, 16'sh7fff, 16'sh8000);
        queue_req(CMD_READ, 16'sh0000, 16'sh0000);

        // four-point frame with full-scale extremes, read out, then an extra read
        settle_and_write_size(3'd1);
        queue_req(CMD_WRITE, 16'sh7fff, 16'sh7fff);
        queue_req(CMD_WRITE, 16'sh8000, 16'sh8000);
        queue_req(CMD_WRITE, 16'sh7fff, 16'sh8000);
        queue_req(CMD_WRITE, 16'sh8000, 16'sh7fff);
        repeat (5) queue_req(CMD_READ, 16'sh0000, 16'sh0000);
        // held frame dropped by a write part way through reading
        repeat (4) queue_req(CMD_WRITE, 16'sh7fff, 16'sh0000);
        queue_req(CMD_READ, 16'sh0000, 16'sh0000);
        repeat (4) queue_req(CMD_WRITE, 16'sh0001, 16'shffff);
        repeat (4) queue_req(CMD_READ, 16'sh0000, 16'sh0000);
        // partial frame then read, then abandoned by the size write
        repeat (2) queue_req(CMD_WRITE, 16'sh1234, 16'sh8765);
        queue_req(CMD_READ, 16'sh0000, 16'sh0000);

        // exponent below range behaves as one
        settle_and_write_size(3'd0);
        queue_frames(1);

        // long stall on the result side while reads keep coming
        settle_and_write_size(3'd2);
        hold_req <= hold_req + 1;
        repeat (40) queue_req(CMD_READ, rand_sample(), rand_sample());
        queue_frames(2);

        // exponents above range behave as the largest
        settle_and_write_size(3'd7);
        repeat (3) queue_req(CMD_WRITE, rand_sample(), rand_sample());
        repeat (2) queue_req(CMD_READ, rand_sample(), rand_sample());

        settle_and_write_size(3'd4);
        queue_frames(1);

        settle_and_write_size(3'd2);
        in_burst = 1'b1;
        queue_frames(1);
        wait_drained();
        in_burst = 1'b0;

        settle_and_write_size(3'd5);
        repeat (5) queue_req(CMD_WRITE, rand_sample(), rand_sample());

        settle_and_write_size(3'd3);
        queue_frames(1);

        // random phases with small frames until the item count is reached
        while (req_total < 700) begin
            rand_cfg = 3'($urandom_range(0, 3));
            settle_and_write_size(rand_cfg);
            in_burst = ($urandom_range(0, 4) == 0);
            queue_frames($urandom_range(1, 4));
            for (int i = 0; i < $urandom_range(0, 6); i++)
                queue_req(1'($urandom_range(0, 1)), rand_sample(), rand_sample());
            wait_drained();
            in_burst = 1'b0;
        end

        wait_drained();
        repeat (10 * used_log4() * (1 << (2 * used_log4())) / 4 + 200) @(posedge i_clk);
        if (fail_count == 0 && expected_bins.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
